// ===== sv/anharmonic_oscillator_integrator_top_assert.svh =====
// Assertion macros for the oscillator integrator checker.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is low.
`ifndef ANHARMONIC_OSCILLATOR_INTEGRATOR_TOP_ASSERT_SVH
`define ANHARMONIC_OSCILLATOR_INTEGRATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define AOI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AOI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/aoi_pkg.sv =====
// ----------------------------------------------------------------------------
// aoi_pkg
// Types, constants and the microprogram of the oscillator integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package aoi_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 24;
  localparam int ENERGY_W = 48;
  localparam int DATA_W   = 48;
  localparam int PC_W     = 7;
  localparam int IDX_W    = 3;

  localparam logic [DATA_W-1:0] SIXTH_C = 48'd2796203;
  localparam logic [DATA_W-1:0] ONE_C   = 48'd1;

  localparam logic [FRAC_W-1:0] STEP_RST = 24'd16777;
  localparam logic [WORD_W-1:0] UNIT_RST = 32'h0100_0000;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_STEP   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_K1     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_K2     = 3'd2;
  localparam logic [IDX_W-1:0] CFG_METHOD = 3'd3;
  localparam logic [IDX_W-1:0] CFG_X0     = 3'd4;
  localparam logic [IDX_W-1:0] CFG_V0     = 3'd5;

  // Microprogram entry points
  localparam logic [PC_W-1:0] PC_RK4    = 7'd0;
  localparam logic [PC_W-1:0] PC_LFINIT = 7'd55;
  localparam logic [PC_W-1:0] PC_LF     = 7'd60;
  localparam logic [PC_W-1:0] PC_ENERGY = 7'd74;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_ADD = 3'd1,
    OP_NEG = 3'd2,
    OP_GOE = 3'd3,
    OP_END = 3'd4
  } op_e;

  typedef enum logic [4:0] {
    R_X    = 5'd0,
    R_V    = 5'd1,
    R_A    = 5'd2,
    R_XS   = 5'd3,
    R_VS   = 5'd4,
    R_SX   = 5'd5,
    R_SV   = 5'd6,
    R_P    = 5'd7,
    R_R    = 5'd8,
    R_D    = 5'd9,
    R_E    = 5'd10,
    R_T    = 5'd11,
    R_Q    = 5'd12,
    C_H    = 5'd13,
    C_K1   = 5'd14,
    C_K2   = 5'd15,
    C_SIX  = 5'd16,
    C_ONE  = 5'd17,
    C_ZERO = 5'd18
  } reg_e;

  typedef enum logic [1:0] {
    SH_HALF  = 2'd0,
    SH_FRAC  = 2'd1,
    SH_FRAC1 = 2'd2,
    SH_FRAC2 = 2'd3
  } shsel_e;

  typedef struct packed {
    op_e    op;
    reg_e   a;
    reg_e   b;
    reg_e   dst;
    shsel_e sh;
    logic   wide;
  } instr_t;

  typedef struct packed {
    instr_t ins;
    logic   alu_we;
    logic   mul_start;
    logic   mul_we;
    logic   load;
    logic   out_load;
  } ctl_t;

  function automatic instr_t mk(op_e op, reg_e a, reg_e b, reg_e d, shsel_e sh,
                                logic w);
    instr_t i;
    i.op   = op;
    i.a    = a;
    i.b    = b;
    i.dst  = d;
    i.sh   = sh;
    i.wide = w;
    return i;
  endfunction

  // Microprogram: Runge-Kutta, leapfrog (with first-step acceleration) and energy
  function automatic instr_t rom(logic [PC_W-1:0] pc);
    instr_t i;
    unique case (pc)
      7'd0:  i = mk(OP_MUL, C_H,  R_V,    R_D,  SH_FRAC, 1'b0);
      7'd1:  i = mk(OP_ADD, R_D,  C_ZERO, R_SX, SH_FRAC, 1'b0);
      7'd2:  i = mk(OP_MUL, R_X,  R_X,    R_Q,  SH_FRAC, 1'b0);
      7'd3:  i = mk(OP_MUL, C_K2, R_Q,    R_T,  SH_FRAC, 1'b0);
      7'd4:  i = mk(OP_ADD, R_T,  C_K1,   R_T,  SH_FRAC, 1'b0);
      7'd5:  i = mk(OP_MUL, R_T,  R_X,    R_T,  SH_FRAC, 1'b0);
      7'd6:  i = mk(OP_NEG, R_T,  C_ZERO, R_E,  SH_FRAC, 1'b0);
      7'd7:  i = mk(OP_MUL, C_H,  R_E,    R_E,  SH_FRAC, 1'b0);
      7'd8:  i = mk(OP_ADD, R_E,  C_ZERO, R_SV, SH_FRAC, 1'b0);
      7'd9:  i = mk(OP_MUL, R_D,  C_ONE,  R_D,  SH_HALF, 1'b0);
      7'd10: i = mk(OP_ADD, R_X,  R_D,    R_XS, SH_FRAC, 1'b0);
      7'd11: i = mk(OP_MUL, R_E,  C_ONE,  R_E,  SH_HALF, 1'b0);
      7'd12: i = mk(OP_ADD, R_V,  R_E,    R_VS, SH_FRAC, 1'b0);
      7'd13: i = mk(OP_MUL, C_H,  R_VS,   R_D,  SH_FRAC, 1'b0);
      7'd14: i = mk(OP_MUL, R_XS, R_XS,   R_Q,  SH_FRAC, 1'b0);
      7'd15: i = mk(OP_MUL, C_K2, R_Q,    R_T,  SH_FRAC, 1'b0);
      7'd16: i = mk(OP_ADD, R_T,  C_K1,   R_T,  SH_FRAC, 1'b0);
      7'd17: i = mk(OP_MUL, R_T,  R_XS,   R_T,  SH_FRAC, 1'b0);
      7'd18: i = mk(OP_NEG, R_T,  C_ZERO, R_E,  SH_FRAC, 1'b0);
      7'd19: i = mk(OP_MUL, C_H,  R_E,    R_E,  SH_FRAC, 1'b0);
      7'd20: i = mk(OP_ADD, R_D,  C_ZERO, R_P,  SH_FRAC, 1'b0);
      7'd21: i = mk(OP_ADD, R_E,  C_ZERO, R_R,  SH_FRAC, 1'b0);
      7'd22: i = mk(OP_MUL, R_D,  C_ONE,  R_D,  SH_HALF, 1'b0);
      7'd23: i = mk(OP_ADD, R_X,  R_D,    R_XS, SH_FRAC, 1'b0);
      7'd24: i = mk(OP_MUL, R_E,  C_ONE,  R_E,  SH_HALF, 1'b0);
      7'd25: i = mk(OP_ADD, R_V,  R_E,    R_VS, SH_FRAC, 1'b0);
      7'd26: i = mk(OP_MUL, C_H,  R_VS,   R_D,  SH_FRAC, 1'b0);
      7'd27: i = mk(OP_MUL, R_XS, R_XS,   R_Q,  SH_FRAC, 1'b0);
      7'd28: i = mk(OP_MUL, C_K2, R_Q,    R_T,  SH_FRAC, 1'b0);
      7'd29: i = mk(OP_ADD, R_T,  C_K1,   R_T,  SH_FRAC, 1'b0);
      7'd30: i = mk(OP_MUL, R_T,  R_XS,   R_T,  SH_FRAC, 1'b0);
      7'd31: i = mk(OP_NEG, R_T,  C_ZERO, R_E,  SH_FRAC, 1'b0);
      7'd32: i = mk(OP_MUL, C_H,  R_E,    R_E,  SH_FRAC, 1'b0);
      7'd33: i = mk(OP_ADD, R_P,  R_D,    R_P,  SH_FRAC, 1'b0);
      7'd34: i = mk(OP_ADD, R_R,  R_E,    R_R,  SH_FRAC, 1'b0);
      7'd35: i = mk(OP_ADD, R_X,  R_D,    R_XS, SH_FRAC, 1'b0);
      7'd36: i = mk(OP_ADD, R_V,  R_E,    R_VS, SH_FRAC, 1'b0);
      7'd37: i = mk(OP_MUL, C_H,  R_VS,   R_D,  SH_FRAC, 1'b0);
      7'd38: i = mk(OP_MUL, R_XS, R_XS,   R_Q,  SH_FRAC, 1'b0);
      7'd39: i = mk(OP_MUL, C_K2, R_Q,    R_T,  SH_FRAC, 1'b0);
      7'd40: i = mk(OP_ADD, R_T,  C_K1,   R_T,  SH_FRAC, 1'b0);
      7'd41: i = mk(OP_MUL, R_T,  R_XS,   R_T,  SH_FRAC, 1'b0);
      7'd42: i = mk(OP_NEG, R_T,  C_ZERO, R_E,  SH_FRAC, 1'b0);
      7'd43: i = mk(OP_MUL, C_H,  R_E,    R_E,  SH_FRAC, 1'b0);
      7'd44: i = mk(OP_ADD, R_P,  R_P,    R_P,  SH_FRAC, 1'b0);
      7'd45: i = mk(OP_ADD, R_SX, R_P,    R_SX, SH_FRAC, 1'b0);
      7'd46: i = mk(OP_ADD, R_SX, R_D,    R_SX, SH_FRAC, 1'b0);
      7'd47: i = mk(OP_ADD, R_R,  R_R,    R_R,  SH_FRAC, 1'b0);
      7'd48: i = mk(OP_ADD, R_SV, R_R,    R_SV, SH_FRAC, 1'b0);
      7'd49: i = mk(OP_ADD, R_SV, R_E,    R_SV, SH_FRAC, 1'b0);
      7'd50: i = mk(OP_MUL, R_SX, C_SIX,  R_SX, SH_FRAC, 1'b0);
      7'd51: i = mk(OP_ADD, R_X,  R_SX,   R_X,  SH_FRAC, 1'b0);
      7'd52: i = mk(OP_MUL, R_SV, C_SIX,  R_SV, SH_FRAC, 1'b0);
      7'd53: i = mk(OP_ADD, R_V,  R_SV,   R_V,  SH_FRAC, 1'b0);
      7'd54: i = mk(OP_GOE, R_X,  R_X,    R_X,  SH_FRAC, 1'b0);
      7'd55: i = mk(OP_MUL, R_X,  R_X,    R_Q,  SH_FRAC, 1'b0);
      7'd56: i = mk(OP_MUL, C_K2, R_Q,    R_T,  SH_FRAC, 1'b0);
      7'd57: i = mk(OP_ADD, R_T,  C_K1,   R_T,  SH_FRAC, 1'b0);
      7'd58: i = mk(OP_MUL, R_T,  R_X,    R_T,  SH_FRAC, 1'b0);
      7'd59: i = mk(OP_NEG, R_T,  C_ZERO, R_A,  SH_FRAC, 1'b0);
      7'd60: i = mk(OP_MUL, C_H,  R_A,    R_E,  SH_FRAC, 1'b0);
      7'd61: i = mk(OP_MUL, R_E,  C_ONE,  R_E,  SH_HALF, 1'b0);
      7'd62: i = mk(OP_ADD, R_V,  R_E,    R_V,  SH_FRAC, 1'b0);
      7'd63: i = mk(OP_MUL, C_H,  R_V,    R_D,  SH_FRAC, 1'b0);
      7'd64: i = mk(OP_ADD, R_X,  R_D,    R_X,  SH_FRAC, 1'b0);
      7'd65: i = mk(OP_MUL, R_X,  R_X,    R_Q,  SH_FRAC, 1'b0);
      7'd66: i = mk(OP_MUL, C_K2, R_Q,    R_T,  SH_FRAC, 1'b0);
      7'd67: i = mk(OP_ADD, R_T,  C_K1,   R_T,  SH_FRAC, 1'b0);
      7'd68: i = mk(OP_MUL, R_T,  R_X,    R_T,  SH_FRAC, 1'b0);
      7'd69: i = mk(OP_NEG, R_T,  C_ZERO, R_A,  SH_FRAC, 1'b0);
      7'd70: i = mk(OP_MUL, C_H,  R_A,    R_E,  SH_FRAC, 1'b0);
      7'd71: i = mk(OP_MUL, R_E,  C_ONE,  R_E,  SH_HALF, 1'b0);
      7'd72: i = mk(OP_ADD, R_V,  R_E,    R_V,  SH_FRAC, 1'b0);
      7'd73: i = mk(OP_GOE, R_X,  R_X,    R_X,  SH_FRAC, 1'b0);
      7'd74: i = mk(OP_MUL, R_V,  R_V,    R_T,  SH_FRAC1, 1'b1);
      7'd75: i = mk(OP_MUL, R_X,  R_X,    R_Q,  SH_FRAC, 1'b1);
      7'd76: i = mk(OP_MUL, C_K1, R_Q,    R_D,  SH_FRAC1, 1'b1);
      7'd77: i = mk(OP_MUL, R_Q,  R_Q,    R_Q,  SH_FRAC, 1'b1);
      7'd78: i = mk(OP_MUL, C_K2, R_Q,    R_E,  SH_FRAC2, 1'b1);
      7'd79: i = mk(OP_ADD, R_T,  R_D,    R_T,  SH_FRAC, 1'b1);
      7'd80: i = mk(OP_ADD, R_T,  R_E,    R_T,  SH_FRAC, 1'b1);
      default: i = mk(OP_END, R_X, R_X,   R_X,  SH_FRAC, 1'b0);
    endcase
    return i;
  endfunction

endpackage

`default_nettype wire

// ===== sv/aoi_mul.sv =====
// ----------------------------------------------------------------------------
// aoi_mul
// Shared multi-cycle multiplier: exact product, round half away from zero,
// shift and saturate to 32 or 48 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aoi_mul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [aoi_pkg::DATA_W-1:0] a_i,
  input  wire logic [aoi_pkg::DATA_W-1:0] b_i,
  input  wire aoi_pkg::shsel_e            sh_i,
  input  wire logic                       wide_i,
  output logic                            done_o,
  output logic [aoi_pkg::DATA_W-1:0]      res_o
);
  import aoi_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_FIN  = 4'b1000
  } mstate_e;

  mstate_e           state_q, state_d;
  logic              done_q;
  logic [DATA_W-1:0] ma_q, mb_q, res_q;
  logic              neg_q, wide_q;
  shsel_e            sh_q;
  logic [95:0]       acc_q;
  logic [23:0]       chunk;
  logic [71:0]       pp;
  logic [95:0]       rnd, shd;
  logic [DATA_W-1:0] mag, sgn, sat_v;
  logic              over;

  // Advance the phase sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE: if (start_i) state_d = M_LO;
      M_LO:   state_d = M_HI;
      M_HI:   state_d = M_FIN;
      M_FIN:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_FIN);
    end
  end

  // One 48x24 partial product per cycle
  assign chunk = (state_q == M_LO) ? mb_q[23:0] : mb_q[47:24];
  assign pp    = 72'(ma_q) * 72'(chunk);

  // Round, shift and saturate
  always_comb begin
    unique case (sh_q)
      SH_HALF: begin
        rnd = acc_q + 96'd1;
        shd = rnd >> 1;
      end
      SH_FRAC: begin
        rnd = acc_q + (96'd1 << (FRAC_W - 1));
        shd = rnd >> FRAC_W;
      end
      SH_FRAC1: begin
        rnd = acc_q + (96'd1 << FRAC_W);
        shd = rnd >> (FRAC_W + 1);
      end
      default: begin
        rnd = acc_q + (96'd1 << (FRAC_W + 1));
        shd = rnd >> (FRAC_W + 2);
      end
    endcase
    over  = wide_q ? (|shd[95:47]) : (|shd[95:31]);
    mag   = shd[DATA_W-1:0];
    sgn   = neg_q ? (48'd0 - mag) : mag;
    if (wide_q) begin
      sat_v = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end else begin
      sat_v = neg_q ? 48'hFFFF_8000_0000 : 48'h0000_7FFF_FFFF;
    end
  end

  // Hold operands and accumulate
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      M_IDLE: begin
        if (start_i) begin
          ma_q   <= a_i[DATA_W-1] ? (48'd0 - a_i) : a_i;
          mb_q   <= b_i[DATA_W-1] ? (48'd0 - b_i) : b_i;
          neg_q  <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
          sh_q   <= sh_i;
          wide_q <= wide_i;
        end
      end
      M_LO:  acc_q <= 96'(pp);
      M_HI:  acc_q <= acc_q + (96'(pp) << 24);
      M_FIN: res_q <= over ? sat_v : sgn;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== sv/aoi_ctrl.sv =====
// ----------------------------------------------------------------------------
// aoi_ctrl
// Microprogram sequencer: program counter, instruction fetch, item handshake
// and the held-acceleration valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module aoi_ctrl (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  restart_i,
  input  wire logic  method_i,
  input  wire logic  clr_av_i,
  input  wire logic  mul_done_i,
  input  wire logic  out_valid_i,
  input  wire logic  out_ready_i,
  output logic       in_ready_o,
  output aoi_pkg::ctl_t ctl_o
);
  import aoi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } cstate_e;

  cstate_e         state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            av_q, av_d;
  instr_t          ins;

  assign ins = rom(pc_q);

  // Sequence the microprogram
  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    av_d          = clr_av_i ? 1'b0 : av_q;
    ctl_o.ins       = ins;
    ctl_o.alu_we    = 1'b0;
    ctl_o.mul_start = 1'b0;
    ctl_o.mul_we    = 1'b0;
    ctl_o.load      = 1'b0;
    ctl_o.out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
          priority if (restart_i) begin
            ctl_o.load = 1'b1;
            pc_d       = PC_ENERGY;
            av_d       = 1'b0;
          end else if (method_i) begin
            pc_d = av_q ? PC_LF : PC_LFINIT;
            av_d = 1'b1;
          end else begin
            pc_d = PC_RK4;
            av_d = 1'b0;
          end
        end
      end
      S_EXEC: begin
        unique case (ins.op)
          OP_MUL: begin
            ctl_o.mul_start = 1'b1;
            state_d         = S_WAIT;
          end
          OP_ADD, OP_NEG: begin
            ctl_o.alu_we = 1'b1;
            pc_d         = pc_q + 7'd1;
          end
          OP_GOE: pc_d = PC_ENERGY;
          default: state_d = S_OUT;
        endcase
      end
      S_WAIT: begin
        if (mul_done_i) begin
          ctl_o.mul_we = 1'b1;
          pc_d         = pc_q + 7'd1;
          state_d      = S_EXEC;
        end
      end
      S_OUT: begin
        if (!out_valid_i || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= PC_RK4;
      av_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      av_q    <= av_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

// ===== sv/anharmonic_oscillator_integrator_top.sv =====
// ----------------------------------------------------------------------------
// anharmonic_oscillator_integrator_top
// Duffing oscillator stepper, Runge-Kutta four or leapfrog, Q8.24 datapath.
// ----------------------------------------------------------------------------
// One item is taken at a time. A sequencer steps through a microprogram that
// runs every product on one shared multiplier and every saturating add or
// negate directly in its execute state. A restart item only reloads the start
// state and computes the energy; a leapfrog step also computes the starting
// acceleration when it is the first step after a restart, a Runge-Kutta step
// or a stiffness write. The result sits in an output register, so the next
// item is taken while it waits.
`default_nettype none

module anharmonic_oscillator_integrator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [aoi_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire logic [aoi_pkg::WORD_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          restart_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [aoi_pkg::WORD_W-1:0]   position_o,
  output logic signed [aoi_pkg::WORD_W-1:0]   velocity_o,
  output logic signed [aoi_pkg::ENERGY_W-1:0] total_energy_o
);
  import aoi_pkg::*;

  logic [FRAC_W-1:0] step_q;
  logic [WORD_W-1:0] k1_q, k2_q, x0_q, v0_q;
  logic              method_q;
  logic [DATA_W-1:0] x_q, v_q, a_q, xs_q, vs_q, sx_q, sv_q, p_q, r_q, d_q, e_q, t_q, q_q;
  logic [DATA_W-1:0] opa, opb, alu_res, mul_res, wdata;
  logic [48:0]       sum;
  logic              mul_done, clr_av, out_valid_q;
  ctl_t              ctl;

  function automatic logic [DATA_W-1:0] sel(reg_e s,
      logic [DATA_W-1:0] x, logic [DATA_W-1:0] v, logic [DATA_W-1:0] a,
      logic [DATA_W-1:0] xs, logic [DATA_W-1:0] vs, logic [DATA_W-1:0] sx,
      logic [DATA_W-1:0] sv, logic [DATA_W-1:0] p, logic [DATA_W-1:0] r,
      logic [DATA_W-1:0] d, logic [DATA_W-1:0] e, logic [DATA_W-1:0] t,
      logic [DATA_W-1:0] q, logic [FRAC_W-1:0] h, logic [WORD_W-1:0] k1,
      logic [WORD_W-1:0] k2);
    logic [DATA_W-1:0] o;
    unique case (s)
      R_X:    o = x;
      R_V:    o = v;
      R_A:    o = a;
      R_XS:   o = xs;
      R_VS:   o = vs;
      R_SX:   o = sx;
      R_SV:   o = sv;
      R_P:    o = p;
      R_R:    o = r;
      R_D:    o = d;
      R_E:    o = e;
      R_T:    o = t;
      R_Q:    o = q;
      C_H:    o = 48'(h);
      C_K1:   o = {{(DATA_W-WORD_W){k1[WORD_W-1]}}, k1};
      C_K2:   o = {{(DATA_W-WORD_W){k2[WORD_W-1]}}, k2};
      C_SIX:  o = SIXTH_C;
      C_ONE:  o = ONE_C;
      default: o = '0;
    endcase
    return o;
  endfunction

  // Take configuration writes
  assign clr_av = cfg_we_i && ((cfg_idx_i == CFG_K1) || (cfg_idx_i == CFG_K2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_RST;
      k1_q     <= UNIT_RST;
      k2_q     <= '0;
      method_q <= 1'b0;
      x0_q     <= UNIT_RST;
      v0_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP:   step_q   <= cfg_data_i[FRAC_W-1:0];
        CFG_K1:     k1_q     <= cfg_data_i;
        CFG_K2:     k2_q     <= cfg_data_i;
        CFG_METHOD: method_q <= cfg_data_i[0];
        CFG_X0:     x0_q     <= cfg_data_i;
        CFG_V0:     v0_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aoi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .restart_i   (restart_i),
    .method_i    (method_q),
    .clr_av_i    (clr_av),
    .mul_done_i  (mul_done),
    .out_valid_i (out_valid_q),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .ctl_o       (ctl)
  );

  // Select operands
  assign opa = sel(ctl.ins.a, x_q, v_q, a_q, xs_q, vs_q, sx_q, sv_q, p_q, r_q, d_q,
                   e_q, t_q, q_q, step_q, k1_q, k2_q);
  assign opb = sel(ctl.ins.b, x_q, v_q, a_q, xs_q, vs_q, sx_q, sv_q, p_q, r_q, d_q,
                   e_q, t_q, q_q, step_q, k1_q, k2_q);

  aoi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .sh_i    (ctl.ins.sh),
    .wide_i  (ctl.ins.wide),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // Saturating add and negate
  assign sum = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};

  always_comb begin
    if (ctl.ins.op == OP_NEG) begin
      alu_res = (opa == 48'hFFFF_8000_0000) ? 48'h0000_7FFF_FFFF : (48'd0 - opa);
    end else if (ctl.ins.wide) begin
      priority if (!sum[48] && sum[47]) alu_res = 48'h7FFF_FFFF_FFFF;
      else if (sum[48] && !sum[47])     alu_res = 48'h8000_0000_0000;
      else                              alu_res = sum[DATA_W-1:0];
    end else begin
      priority if (!sum[48] && (|sum[47:31])) alu_res = 48'h0000_7FFF_FFFF;
      else if (sum[48] && !(&sum[47:31]))     alu_res = 48'hFFFF_8000_0000;
      else                                    alu_res = sum[DATA_W-1:0];
    end
  end

  assign wdata = ctl.mul_we ? mul_res : alu_res;

  // Update position and velocity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= 48'(UNIT_RST);
      v_q <= '0;
    end else if (ctl.load) begin
      x_q <= {{(DATA_W-WORD_W){x0_q[WORD_W-1]}}, x0_q};
      v_q <= {{(DATA_W-WORD_W){v0_q[WORD_W-1]}}, v0_q};
    end else if (ctl.alu_we || ctl.mul_we) begin
      if (ctl.ins.dst == R_X) x_q <= wdata;
      if (ctl.ins.dst == R_V) v_q <= wdata;
    end
  end

  // Write scratch registers
  always_ff @(posedge clk_i) begin
    if (ctl.alu_we || ctl.mul_we) begin
      unique case (ctl.ins.dst)
        R_A:  a_q  <= wdata;
        R_XS: xs_q <= wdata;
        R_VS: vs_q <= wdata;
        R_SX: sx_q <= wdata;
        R_SV: sv_q <= wdata;
        R_P:  p_q  <= wdata;
        R_R:  r_q  <= wdata;
        R_D:  d_q  <= wdata;
        R_E:  e_q  <= wdata;
        R_T:  t_q  <= wdata;
        R_Q:  q_q  <= wdata;
        default: ;
      endcase
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      position_o     <= x_q[WORD_W-1:0];
      velocity_o     <= v_q[WORD_W-1:0];
      total_energy_o <= t_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/aoi_checker.sv =====
// ----------------------------------------------------------------------------
// aoi_checker
// Port-level checks of the oscillator integrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "anharmonic_oscillator_integrator_top_assert.svh"

module aoi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] position_o
);

  // Busy right after taking an item
  `AOI_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after input transfer")
  // A fresh result frees the input side
  `AOI_ASSERT_IMP(a_ready_with_result, clk_i, rst_ni, $rose(out_valid_o), in_ready_o, "result shown while busy")
  // Hold a stalled result
  `AOI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `AOI_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(position_o), "result changed while stalled")

endmodule

bind anharmonic_oscillator_integrator_top aoi_checker u_aoi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .position_o  (position_o)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the anharmonic oscillator integrator.
// ----------------------------------------------------------------------------
// Drives restart and step items through the valid/ready input channel, keeps
// its own fixed-point copy of the oscillator state, and compares every
// transfer on the result channel with the oldest predicted state. Runs the
// Runge-Kutta and leapfrog methods over several step sizes and stiffness
// settings, including the extremes, under changing idle and stall patterns.
`default_nettype none

module tb_top;
  import aoi_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;

  typedef struct packed {
    logic signed [WORD_W-1:0]   pos;
    logic signed [WORD_W-1:0]   vel;
    logic signed [ENERGY_W-1:0] nrg;
  } osc_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [WORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [WORD_W-1:0] position;
  logic signed [WORD_W-1:0] velocity;
  logic signed [ENERGY_W-1:0] total_energy;

  // Predictor copy of configuration and state
  logic [63:0] m_h;
  logic signed [63:0] m_k1, m_k2, m_x0, m_v0, m_x, m_v, m_acc;
  logic m_lf, m_acc_ok;

  osc_state_t pending_states[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  longint cycles = 0;

  anharmonic_oscillator_integrator_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .restart_i     (restart),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .position_o    (position),
    .velocity_o    (velocity),
    .total_energy_o(total_energy)
  );

  always #10 clk = ~clk;

  // Saturating limits of a w-bit signed word
  function automatic logic signed [63:0] lim_hi(int w);
    return (64'sd1 <<< (w - 1)) - 1;
  endfunction

  function automatic logic signed [63:0] sat(logic signed [127:0] a, int w);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (a > hi) return hi[63:0];
    if (a < lo) return lo[63:0];
    return a[63:0];
  endfunction

  // Exact product, shifted with round half away from zero, saturated
  function automatic logic signed [63:0] prod_rnd(logic signed [63:0] a, logic signed [63:0] b,
                                                  int sh, int w);
    logic signed [127:0] p, m;
    p = 128'(a) * 128'(b);
    m = (p < 0) ? -p : p;
    if (sh > 0) m = (m + (128'sd1 <<< (sh - 1))) >>> sh;
    return sat((p < 0) ? -m : m, w);
  endfunction

  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    return prod_rnd(a, b, FRAC_W, WORD_W);
  endfunction

  function automatic logic signed [63:0] qadd(logic signed [63:0] a, logic signed [63:0] b,
                                              int w = WORD_W);
    return sat(128'(a) + 128'(b), w);
  endfunction

  function automatic logic signed [63:0] qhalf(logic signed [63:0] a);
    return prod_rnd(a, 64'sd1, 1, WORD_W);
  endfunction

  function automatic logic signed [63:0] spring_accel(logic signed [63:0] x);
    logic signed [63:0] s, t;
    s = qadd(qmul(m_k2, qmul(x, x)), m_k1);
    t = qmul(s, x);
    return (t == -lim_hi(WORD_W) - 1) ? lim_hi(WORD_W) : -t;
  endfunction

  function automatic logic signed [63:0] osc_energy(logic signed [63:0] x, logic signed [63:0] v);
    logic signed [63:0] kin, x2, lin, x4, cub;
    kin = prod_rnd(v, v, FRAC_W + 1, ENERGY_W);
    x2  = prod_rnd(x, x, FRAC_W, ENERGY_W);
    lin = prod_rnd(m_k1, x2, FRAC_W + 1, ENERGY_W);
    x4  = prod_rnd(x2, x2, FRAC_W, ENERGY_W);
    cub = prod_rnd(m_k2, x4, FRAC_W + 2, ENERGY_W);
    return qadd(qadd(kin, lin, ENERGY_W), cub, ENERGY_W);
  endfunction

  task automatic advance_runge_kutta();
    logic signed [63:0] h, six, x, v, dx1, dv1, dx2, dv2, dx3, dv3, dx4, dv4;
    logic signed [63:0] xa, va, sx, sv;
    h = m_h;
    six = ((64'sd1 <<< FRAC_W) + 3) / 6;
    x = m_x;
    v = m_v;
    dx1 = qmul(h, v);
    dv1 = qmul(h, spring_accel(x));
    xa = qadd(x, qhalf(dx1));
    va = qadd(v, qhalf(dv1));
    dx2 = qmul(h, va);
    dv2 = qmul(h, spring_accel(xa));
    xa = qadd(x, qhalf(dx2));
    va = qadd(v, qhalf(dv2));
    dx3 = qmul(h, va);
    dv3 = qmul(h, spring_accel(xa));
    xa = qadd(x, dx3);
    va = qadd(v, dv3);
    dx4 = qmul(h, va);
    dv4 = qmul(h, spring_accel(xa));
    sx = qadd(dx2, dx3);
    sv = qadd(dv2, dv3);
    sx = qadd(qadd(dx1, qadd(sx, sx)), dx4);
    sv = qadd(qadd(dv1, qadd(sv, sv)), dv4);
    m_x = qadd(x, qmul(sx, six));
    m_v = qadd(v, qmul(sv, six));
    m_acc_ok = 1'b0;
  endtask

  task automatic advance_leapfrog();
    if (!m_acc_ok) begin
      m_acc = spring_accel(m_x);
      m_acc_ok = 1'b1;
    end
    m_v = qadd(m_v, qhalf(qmul(m_h, m_acc)));
    m_x = qadd(m_x, qmul(m_h, m_v));
    m_acc = spring_accel(m_x);
    m_v = qadd(m_v, qhalf(qmul(m_h, m_acc)));
  endtask

  // Update the predicted state for one item and queue the expected result
  task automatic predict_item(logic rs);
    osc_state_t s;
    logic signed [63:0] nrg;
    if (rs) begin
      m_x = m_x0;
      m_v = m_v0;
      m_acc_ok = 1'b0;
    end else if (m_lf) begin
      advance_leapfrog();
    end else begin
      advance_runge_kutta();
    end
    nrg = osc_energy(m_x, m_v);
    s.pos = m_x[WORD_W-1:0];
    s.vel = m_v[WORD_W-1:0];
    s.nrg = nrg[ENERGY_W-1:0];
    pending_states.push_back(s);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_STEP:   m_h = {40'd0, val[FRAC_W-1:0]};
      CFG_K1:     begin m_k1 = $signed(val); m_acc_ok = 1'b0; end
      CFG_K2:     begin m_k2 = $signed(val); m_acc_ok = 1'b0; end
      CFG_METHOD: m_lf = val[0];
      CFG_X0:     m_x0 = $signed(val);
      CFG_V0:     m_v0 = $signed(val);
      default: ;
    endcase
  endtask

  // Present one item, hold it until the transfer
  task automatic send_item(logic rs);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(rs);
  endtask

  // Drop valid, wait for all results, then for the block to go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic configure(logic [23:0] h, logic [31:0] k1, logic [31:0] k2, logic lf,
                           logic [31:0] x0, logic [31:0] v0);
    drain();
    write_reg(CFG_STEP, {8'd0, h});
    write_reg(CFG_K1, k1);
    write_reg(CFG_K2, k2);
    write_reg(CFG_METHOD, {31'd0, lf});
    write_reg(CFG_X0, x0);
    write_reg(CFG_V0, v0);
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    osc_state_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_states.size() == 0) begin
        $display("%0t result with nothing expected: pos %h vel %h nrg %h", $time,
                 position, velocity, total_energy);
        errors++;
      end else begin
        e = pending_states.pop_front();
        if (position !== e.pos) begin
          $display("%0t position expected %h actual %h", $time, e.pos, position);
          errors++;
        end
        if (velocity !== e.vel) begin
          $display("%0t velocity expected %h actual %h", $time, e.vel, velocity);
          errors++;
        end
        if (total_energy !== e.nrg) begin
          $display("%0t energy expected %h actual %h", $time, e.nrg, total_energy);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // Extremes of every register, restart and each method
  task automatic test_directed();
    configure(24'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 32'h7FFFFFFF, 32'h80000000);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    configure(24'd0, 32'h80000000, 32'h80000000, 1'b1, 32'h80000000, 32'h7FFFFFFF);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    configure(24'd16777, 32'h01000000, 32'h00400000, 1'b1, 32'h02000000, 32'h0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    // stiffness write forces the first leapfrog step to recompute
    drain();
    write_reg(CFG_K2, 32'h00800000);
    send_item(1'b0);
    // Runge-Kutta then back to leapfrog
    drain();
    write_reg(CFG_METHOD, 32'd0);
    send_item(1'b0);
    drain();
    write_reg(CFG_METHOD, 32'd1);
    send_item(1'b0);
    // unknown indexes are ignored
    drain();
    write_reg(3'd6, 32'hFFFFFFFF);
    write_reg(3'd7, 32'h12345678);
    send_item(1'b0);
    send_item(1'b1);
  endtask

  task automatic test_random(int n_items);
    int phase;
    for (int i = 0; i < n_items; i++) begin
      if (i % 75 == 0) begin
        phase = (i / 75) % 4;
        send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 10 : 78) : 0;
        recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 10 : 78) : 0;
        if ($urandom_range(3) == 0)
          configure(24'($urandom), $urandom, $urandom, 1'($urandom_range(1)), $urandom,
                    $urandom);
        else
          configure(24'($urandom_range(1, 400000)),
                    $urandom_range(0, 32'h04000000) - 32'h01000000,
                    $urandom_range(0, 32'h02000000) - 32'h01000000,
                    1'($urandom_range(1)),
                    $urandom_range(0, 32'h04000000) - 32'h02000000,
                    $urandom_range(0, 32'h04000000) - 32'h02000000);
        send_item(1'b1);
      end else begin
        send_item($urandom_range(15) == 0);
      end
    end
  endtask

  initial begin
    m_h = 64'(STEP_RST);
    m_k1 = 64'sd1 <<< FRAC_W;
    m_k2 = 0;
    m_lf = 1'b0;
    m_x0 = 64'sd1 <<< FRAC_W;
    m_v0 = 0;
    m_x = 64'sd1 <<< FRAC_W;
    m_v = 0;
    m_acc = 0;
    m_acc_ok = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random(900);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
